/* hw/rtl/nrtbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nrtbs_pkg;

  // Field widths
  localparam int FUNC_W  = 1;
  localparam int PRB_W   = 9;
  localparam int SYM_W   = 4;
  localparam int RE_W    = 8;
  localparam int DRE_W   = 16;
  localparam int RATE_W  = 11;
  localparam int QM_W    = 4;
  localparam int LAY_W   = 3;
  localparam int TBS_W   = 21;

  // Internal widths
  localparam int PER_W   = 11;  // signed REs per PRB before the clamp
  localparam int NRE_W   = 17;  // RE count
  localparam int RQ1_W   = 15;  // rate * Qm
  localparam int RQ_W    = 18;  // rate * Qm * layers
  localparam int X_W     = 35;  // N_info with fraction bits
  localparam int N_W     = 5;   // quantization step exponent
  localparam int NP_W    = 26;  // quantized N_info, sums
  localparam int RCP_W   = 28;  // reciprocal of the code-block limit
  localparam int D1_Q_W   = 14; // code-block count
  localparam int D2_DEN_W = 17; // 8 * C
  localparam int D2_Q_W   = 11;
  localparam int PROD_W   = 28;

  // Constants
  localparam int RE_PER_PRB_MAX = 156;
  localparam int SC_PER_RB      = 12;
  localparam int SMALL_LIMIT    = 3824;
  localparam int LARGE_FLOOR    = 3840;
  localparam int CB_LIMIT       = 8424;
  localparam int CB_LOW_RATE    = 3816;
  localparam int CRC_BITS       = 24;
  localparam int OUT_MAX        = 2097151;
  localparam int TBS_ENTRIES    = 93;

  // Reciprocals of the code-block limits, ceil(2^CB_SHIFT / limit).
  // floor(num * rcp >> CB_SHIFT) is exact for num below 2^25.
  localparam int CB_SHIFT = 39;
  localparam logic [RCP_W-1:0] CB_RCP_LOW =
    RCP_W'(((64'd1 << CB_SHIFT) + 64'(CB_LOW_RATE) - 64'd1) / 64'(CB_LOW_RATE));
  localparam logic [RCP_W-1:0] CB_RCP_LIMIT =
    RCP_W'(((64'd1 << CB_SHIFT) + 64'(CB_LIMIT) - 64'd1) / 64'(CB_LIMIT));

  typedef enum logic [1:0] {
    PATH_SMALL = 2'd0,
    PATH_PLAIN = 2'd1,
    PATH_CB    = 2'd2
  } path_t;

  // TBS table for small N_info
  localparam logic [11:0] SMALL_SIZES [0:TBS_ENTRIES-1] = '{
    12'd24,   12'd32,   12'd40,   12'd48,   12'd56,   12'd64,   12'd72,   12'd80,
    12'd88,   12'd96,   12'd104,  12'd112,  12'd120,  12'd128,  12'd136,  12'd144,
    12'd152,  12'd160,  12'd168,  12'd176,  12'd184,  12'd192,  12'd208,  12'd224,
    12'd240,  12'd256,  12'd272,  12'd288,  12'd304,  12'd320,  12'd336,  12'd352,
    12'd368,  12'd384,  12'd408,  12'd432,  12'd456,  12'd480,  12'd504,  12'd528,
    12'd552,  12'd576,  12'd608,  12'd640,  12'd672,  12'd704,  12'd736,  12'd768,
    12'd808,  12'd848,  12'd888,  12'd928,  12'd984,  12'd1032, 12'd1064, 12'd1128,
    12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352, 12'd1416,
    12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864, 12'd1928,
    12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472, 12'd2536,
    12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104, 12'd3240,
    12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
  };

endpackage

`default_nettype wire

/* hw/rtl/nrtbs_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nrtbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [nrtbs_pkg::FUNC_W-1:0] func;
  logic [nrtbs_pkg::PRB_W-1:0]  prb_count;
  logic [nrtbs_pkg::SYM_W-1:0]  symbol_count;
  logic [nrtbs_pkg::RE_W-1:0]   dmrs_re_per_prb;
  logic [nrtbs_pkg::RE_W-1:0]   overhead_re_per_prb;
  logic [nrtbs_pkg::DRE_W-1:0]  data_re_count;
  logic [nrtbs_pkg::RATE_W-1:0] rate_x1024;
  logic [nrtbs_pkg::QM_W-1:0]   mod_order;
  logic [nrtbs_pkg::LAY_W-1:0]  layer_count;

  modport source (
    output valid, func, prb_count, symbol_count, dmrs_re_per_prb,
           overhead_re_per_prb, data_re_count, rate_x1024, mod_order, layer_count,
    input  ready
  );
  modport sink (
    input  valid, func, prb_count, symbol_count, dmrs_re_per_prb,
           overhead_re_per_prb, data_re_count, rate_x1024, mod_order, layer_count,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/nrtbs_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nrtbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [nrtbs_pkg::TBS_W-1:0] block_size;

  modport source (output valid, block_size, input ready);
  modport sink (input valid, block_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nrtbs_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in Q_W bits. Tag rides along with the operands.
module nrtbs_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 14,
  parameter int Q_W   = 14,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_vld,
  output logic [Q_W-1:0]        quo,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [0:Q_W-1];
  logic [W-1:0]     rem_r [0:Q_W-2];
  logic [DEN_W-1:0] den_r [0:Q_W-1];
  logic [Q_W-1:0]   quo_r [0:Q_W-1];
  logic [TAG_W-1:0] tag_r [0:Q_W-1];

  for (genvar i = 0; i < Q_W; i++) begin : g_st
    logic             vld_in;
    logic [W-1:0]     rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [W-1:0]     sub;
    logic [W-1:0]     rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = W'(num);
      assign den_in = den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign sub = W'(den_in) << (Q_W - 1 - i);

    // trial subtract for this quotient bit
    always_comb begin
      if (rem_in >= sub) begin
        rem_nxt = rem_in - sub;
        quo_nxt = quo_in | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        rem_nxt = rem_in;
        quo_nxt = quo_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        quo_r[i] <= quo_nxt;
        tag_r[i] <= tag_in;
      end
    end

    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
        end
      end
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign quo     = quo_r[Q_W-1];
  assign out_tag = tag_r[Q_W-1];

endmodule

`default_nettype wire

/* hw/rtl/nr_transport_block_size_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    func, prb_count, symbol_count, dmrs/overhead REs,
//                              data_re_count, rate_x1024, mod_order, layer_count
// out_ch   out  valid/ready    block_size
//
// One grant per cycle while the pipeline is not held; the stages are 7 arithmetic
// stages, a reciprocal multiply for the code-block count, one stage, an 11-stage divider
// for the per-block size, the final multiply and the output register.
// Reset clears every valid bit; payload registers are not reset.
// The whole pipeline holds when the output register is full and not taken,
// so in_ch.ready follows out_ch.ready whenever a result is waiting.
module nr_transport_block_size_top #(
  parameter int RATE_FRAC_BITS = 10
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  nrtbs_in_if.sink     in_ch,
  nrtbs_out_if.source  out_ch
);

  localparam int NRE_W  = nrtbs_pkg::NRE_W;
  localparam int RQ1_W  = nrtbs_pkg::RQ1_W;
  localparam int RQ_W   = nrtbs_pkg::RQ_W;
  localparam int X_W    = nrtbs_pkg::X_W;
  localparam int N_W    = nrtbs_pkg::N_W;
  localparam int NP_W   = nrtbs_pkg::NP_W;
  localparam int PER_W  = nrtbs_pkg::PER_W;
  localparam int RCP_W    = nrtbs_pkg::RCP_W;
  localparam int CP_W     = NP_W + RCP_W;
  localparam int D1_Q_W   = nrtbs_pkg::D1_Q_W;
  localparam int D2_DEN_W = nrtbs_pkg::D2_DEN_W;
  localparam int D2_Q_W   = nrtbs_pkg::D2_Q_W;
  localparam int PROD_W   = nrtbs_pkg::PROD_W;
  localparam int TBS_W    = nrtbs_pkg::TBS_W;
  localparam int TAG1_W   = 2 + NP_W + NP_W;
  localparam int TAG2_W   = TAG1_W + D2_DEN_W;

  logic adv;
  logic out_vld_r;
  logic [TBS_W-1:0] out_size_r;

  // global advance: pipeline moves unless a finished result is stuck
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: REs per PRB, rate*Qm ----------------
  logic                          s1_vld_r;
  logic                          s1_func_r;
  logic [7:0]                    s1_per_r, s1_per_nxt;
  logic [nrtbs_pkg::PRB_W-1:0]   s1_prb_r;
  logic [nrtbs_pkg::DRE_W-1:0]   s1_dre_r;
  logic [nrtbs_pkg::LAY_W-1:0]   s1_lay_r;
  logic [RQ1_W-1:0]              s1_rq_r;
  logic                          s1_low_r, s1_low_nxt;

  always_comb begin
    logic signed [PER_W-1:0] per;
    per = PER_W'(signed'({1'b0, in_ch.symbol_count}) * nrtbs_pkg::SC_PER_RB)
        - signed'(PER_W'(in_ch.dmrs_re_per_prb))
        - signed'(PER_W'(in_ch.overhead_re_per_prb));
    if (per < 0) begin
      s1_per_nxt = '0;
    end else if (per > PER_W'(nrtbs_pkg::RE_PER_PRB_MAX)) begin
      s1_per_nxt = 8'(nrtbs_pkg::RE_PER_PRB_MAX);
    end else begin
      s1_per_nxt = per[7:0];
    end
    s1_low_nxt = ((18'(in_ch.rate_x1024) << 2) <= (18'd1 << RATE_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= in_ch.func;
      s1_per_r  <= s1_per_nxt;
      s1_prb_r  <= in_ch.prb_count;
      s1_dre_r  <= in_ch.data_re_count;
      s1_lay_r  <= in_ch.layer_count;
      s1_rq_r   <= RQ1_W'(in_ch.rate_x1024) * RQ1_W'(in_ch.mod_order);
      s1_low_r  <= s1_low_nxt;
    end
  end

  // ---------------- stage 2: RE count, times layers ----------------
  logic             s2_vld_r;
  logic [NRE_W-1:0] s2_nre_r;
  logic [RQ_W-1:0]  s2_rq_r;
  logic             s2_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nre_r <= s1_func_r ? NRE_W'(s1_dre_r) : NRE_W'(s1_per_r) * NRE_W'(s1_prb_r);
      s2_rq_r  <= RQ_W'(s1_rq_r) * RQ_W'(s1_lay_r);
      s2_low_r <= s1_low_r;
    end
  end

  // ---------------- stage 3: N_info with fraction bits ----------------
  logic           s3_vld_r;
  logic [X_W-1:0] s3_x_r;
  logic           s3_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x_r   <= X_W'(s2_nre_r) * X_W'(s2_rq_r);
      s3_low_r <= s2_low_r;
    end
  end

  // ---------------- stage 4: pick small or large path ----------------
  logic           s4_vld_r;
  logic [X_W-1:0] s4_v_r;
  logic           s4_small_r, s4_small_nxt;
  logic           s4_low_r;

  assign s4_small_nxt = s3_x_r <= (X_W'(nrtbs_pkg::SMALL_LIMIT) << RATE_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v_r     <= s4_small_nxt ? s3_x_r
                  : s3_x_r - (X_W'(nrtbs_pkg::CRC_BITS) << RATE_FRAC_BITS);
      s4_small_r <= s4_small_nxt;
      s4_low_r   <= s3_low_r;
    end
  end

  // ---------------- stage 5: top bit, step exponent ----------------
  logic           s5_vld_r;
  logic [X_W-1:0] s5_v_r;
  logic [N_W-1:0] s5_n_r, s5_n_nxt;
  logic           s5_small_r;
  logic           s5_low_r;

  always_comb begin
    int t_i;
    int n_i;
    t_i = 0;
    for (int i = 0; i < X_W; i++) begin
      if (s4_v_r[i]) begin
        t_i = i;
      end
    end
    if (s4_small_r) begin
      n_i = t_i - RATE_FRAC_BITS - 6;
      if (n_i < 3 || s4_v_r == '0) begin
        n_i = 3;
      end
    end else begin
      n_i = t_i - RATE_FRAC_BITS - 5;
      if (n_i < 0) begin
        n_i = 0;
      end
    end
    s5_n_nxt = N_W'(n_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_v_r     <= s4_v_r;
      s5_n_r     <= s5_n_nxt;
      s5_small_r <= s4_small_r;
      s5_low_r   <= s4_low_r;
    end
  end

  // ---------------- stage 6: round half up to a multiple of 2^n ----------------
  logic            s6_vld_r;
  logic [NP_W-1:0] s6_np_r, s6_np_nxt;
  logic            s6_small_r;
  logic            s6_low_r;

  always_comb begin
    logic [5:0]   shamt;
    logic [X_W:0] acc;
    shamt = 6'(s5_n_r) + 6'(RATE_FRAC_BITS);
    acc   = {1'b0, s5_v_r} + ((X_W+1)'(1) << (shamt - 6'd1));
    s6_np_nxt = NP_W'((acc >> shamt) << s5_n_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_np_r    <= s6_np_nxt;
      s6_small_r <= s5_small_r;
      s6_low_r   <= s5_low_r;
    end
  end

  // ---------------- stage 7: table lookup, byte alignment, C reciprocal ----------------
  logic                   s7_vld_r;
  nrtbs_pkg::path_t       s7_path_r, s7_path_nxt;
  logic [NP_W-1:0]        s7_sum_r, s7_sum_nxt;
  logic [NP_W-1:0]        s7_pre_r, s7_pre_nxt;
  logic [NP_W-1:0]        s7_num_r, s7_num_nxt;
  logic [RCP_W-1:0]       s7_rcp_r, s7_rcp_nxt;

  always_comb begin
    logic [NP_W-1:0] np_s;
    logic [NP_W-1:0] np_l;
    logic [NP_W-1:0] lim;
    logic [11:0]     tab;
    np_s = (s6_np_r < NP_W'(nrtbs_pkg::CRC_BITS)) ? NP_W'(nrtbs_pkg::CRC_BITS) : s6_np_r;
    np_l = (s6_np_r < NP_W'(nrtbs_pkg::LARGE_FLOOR)) ? NP_W'(nrtbs_pkg::LARGE_FLOOR)
         : s6_np_r;
    // smallest table entry not below np_s, last entry when none is
    tab = nrtbs_pkg::SMALL_SIZES[nrtbs_pkg::TBS_ENTRIES-1];
    for (int i = nrtbs_pkg::TBS_ENTRIES - 1; i >= 0; i--) begin
      if (NP_W'(nrtbs_pkg::SMALL_SIZES[i]) >= np_s) begin
        tab = nrtbs_pkg::SMALL_SIZES[i];
      end
    end
    s7_sum_nxt = np_l + NP_W'(nrtbs_pkg::CRC_BITS);
    lim        = s6_low_r ? NP_W'(nrtbs_pkg::CB_LOW_RATE) : NP_W'(nrtbs_pkg::CB_LIMIT);
    s7_rcp_nxt = s6_low_r ? nrtbs_pkg::CB_RCP_LOW : nrtbs_pkg::CB_RCP_LIMIT;
    s7_num_nxt = s7_sum_nxt + lim - NP_W'(1);
    if (s6_small_r) begin
      s7_path_nxt = nrtbs_pkg::PATH_SMALL;
      s7_pre_nxt  = NP_W'(tab);
    end else begin
      s7_path_nxt = (s6_low_r || np_l > NP_W'(nrtbs_pkg::CB_LIMIT)) ? nrtbs_pkg::PATH_CB
                  : nrtbs_pkg::PATH_PLAIN;
      s7_pre_nxt  = ((s7_sum_nxt + NP_W'(7)) & ~NP_W'(7)) - NP_W'(nrtbs_pkg::CRC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (adv) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_path_r <= s7_path_nxt;
      s7_sum_r  <= s7_sum_nxt;
      s7_pre_r  <= s7_pre_nxt;
      s7_num_r  <= s7_num_nxt;
      s7_rcp_r  <= s7_rcp_nxt;
    end
  end

  // ---------------- code-block count: C = ceil(sum / limit) by reciprocal ----------------
  logic              c_vld_r;
  logic [TAG1_W-1:0] c_tag_r;
  logic [CP_W-1:0]   c_prod_r;
  logic              d1_vld;
  logic [D1_Q_W-1:0] d1_quo;
  logic [TAG1_W-1:0] d1_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag_r  <= {s7_path_r, s7_sum_r, s7_pre_r};
      c_prod_r <= CP_W'(s7_num_r) * CP_W'(s7_rcp_r);
    end
  end

  assign d1_vld = c_vld_r;
  assign d1_quo = c_prod_r[nrtbs_pkg::CB_SHIFT +: D1_Q_W];
  assign d1_tag = c_tag_r;

  // ---------------- stage 8: 8C and numerator for the per-block ceiling ----------------
  logic                s8_vld_r;
  logic [TAG1_W-1:0]   s8_tag_r;
  logic [D2_DEN_W-1:0] s8_d_r, s8_d_nxt;
  logic [NP_W-1:0]     s8_num_r;

  assign s8_d_nxt = {d1_quo, 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (adv) begin
      s8_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_tag_r <= d1_tag;
      s8_d_r   <= s8_d_nxt;
      s8_num_r <= d1_tag[2*NP_W-1:NP_W] + NP_W'(s8_d_nxt) - NP_W'(1);
    end
  end

  // ---------------- divider 2: ceil(sum / 8C) ----------------
  logic              d2_vld;
  logic [D2_Q_W-1:0] d2_quo;
  logic [TAG2_W-1:0] d2_tag;

  nrtbs_div #(
    .NUM_W (NP_W),
    .DEN_W (D2_DEN_W),
    .Q_W   (D2_Q_W),
    .TAG_W (TAG2_W)
  ) u_div_blk (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s8_vld_r),
    .num     (s8_num_r),
    .den     (s8_d_r),
    .in_tag  ({s8_tag_r, s8_d_r}),
    .out_vld (d2_vld),
    .quo     (d2_quo),
    .out_tag (d2_tag)
  );

  // ---------------- stage 9: 8C * ceil(sum / 8C) ----------------
  logic              s9_vld_r;
  nrtbs_pkg::path_t  s9_path_r;
  logic [NP_W-1:0]   s9_sum_r;
  logic [NP_W-1:0]   s9_pre_r;
  logic [PROD_W-1:0] s9_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (adv) begin
      s9_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_path_r <= nrtbs_pkg::path_t'(d2_tag[TAG2_W-1 -: 2]);
      s9_sum_r  <= d2_tag[D2_DEN_W+2*NP_W-1 -: NP_W];
      s9_pre_r  <= d2_tag[D2_DEN_W+NP_W-1 -: NP_W];
      s9_prod_r <= PROD_W'(d2_tag[D2_DEN_W-1:0]) * PROD_W'(d2_quo);
    end
  end

  // ---------------- output register: select and saturate ----------------
  logic [PROD_W-1:0] res;
  logic [TBS_W-1:0]  out_size_nxt;

  always_comb begin
    if (s9_path_r == nrtbs_pkg::PATH_CB) begin
      res = s9_prod_r - PROD_W'(nrtbs_pkg::CRC_BITS);
    end else begin
      res = PROD_W'(s9_pre_r);
    end
    out_size_nxt = (res > PROD_W'(nrtbs_pkg::OUT_MAX)) ? TBS_W'(nrtbs_pkg::OUT_MAX)
                 : res[TBS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_size_r <= out_size_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.block_size = out_size_r;

  // ---------------- checks ----------------
  a_min_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_size_r >= TBS_W'(nrtbs_pkg::CRC_BITS))
    else $error("block size below CRC length");

  a_cb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_vld && d1_tag[TAG1_W-1 -: 2] == nrtbs_pkg::PATH_CB) |-> d1_quo != '0)
    else $error("code-block count is zero");

  a_cb_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (s9_vld_r && s9_path_r == nrtbs_pkg::PATH_CB) |-> s9_prod_r >= PROD_W'(s9_sum_r))
    else $error("aligned size below N_info plus CRC");

endmodule

`default_nettype wire
